@@ rtl/core/ray_annulus_intersect_core_macros.svh @@
// ----------------------------------------------------------------------------
// Ray/annulus core assertion macros
// Concurrent checks on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RAY_ANNULUS_INTERSECT_CORE_MACROS_SVH
`define RAY_ANNULUS_INTERSECT_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define RAI_ASSERT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rai core check failed");
`define RAI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rai core check failed");
`else
`define RAI_ASSERT(label, ante, cons)
`define RAI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/rai_pkg.sv @@
// ----------------------------------------------------------------------------
// rai_pkg
// Widths, register indexes and shared types of the ray/annulus core.
// ----------------------------------------------------------------------------
package rai_pkg;

    localparam int AXES       = 3;
    localparam int COORD_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int NORM_W     = FRAC_W + 2;
    localparam int RAD_W      = COORD_W - 1;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int NPROD_W    = NORM_W + DIFF_W;
    localparam int DPROD_W    = NORM_W + COORD_W;
    localparam int NUM_W      = NPROD_W + 2;
    localparam int DEN_W      = DPROD_W + 2;
    localparam int UN_W       = NUM_W - 1;
    localparam int UD_W       = DEN_W - 1;
    localparam int DVD_W      = UN_W + FRAC_W;
    localparam int T_W        = 2 * COORD_W - 1;
    localparam int TL_W       = COORD_W;
    localparam int TH_W       = T_W - TL_W;
    localparam int DMAG_W     = COORD_W;
    localparam int OFS_W      = T_W + DMAG_W;
    localparam int P_W        = T_W - FRAC_W;
    localparam int HSUM_W     = P_W + 2;
    localparam int EMAG_W     = COORD_W;
    localparam int SQ_W       = 2 * EMAG_W;
    localparam int DIST_W     = SQ_W + 2;
    localparam int RSQ_W      = 2 * RAD_W;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = COORD_W;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CENTRE_X     = 3'd0,
        REG_CENTRE_Y     = 3'd1,
        REG_CENTRE_Z     = 3'd2,
        REG_NORMAL_X     = 3'd3,
        REG_NORMAL_Y     = 3'd4,
        REG_NORMAL_Z     = 3'd5,
        REG_INNER_RADIUS = 3'd6,
        REG_OUTER_RADIUS = 3'd7
    } t_cfg_addr;

    // per-ray data that rides along the pipeline
    typedef struct packed {
        logic [AXES-1:0][COORD_W-1:0] org;
        logic [AXES-1:0][COORD_W-1:0] dir;
        logic                         miss;
        logic                         den_pos;
    } t_side;

endpackage

@@ rtl/core/rai_div_pipe.sv @@
// ----------------------------------------------------------------------------
// rai_div_pipe
// Pipelined restoring divider, one quotient bit per stage. Quotient of
// (i_un << FRAC_W) / i_ud; side data travels with each item.
// ----------------------------------------------------------------------------
module rai_div_pipe (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [rai_pkg::UN_W-1:0]   i_un,
    input  logic [rai_pkg::UD_W-1:0]   i_ud,
    input  rai_pkg::t_side             i_side,
    output logic                       o_vld,
    output logic [rai_pkg::DVD_W-1:0]  o_quo,
    output rai_pkg::t_side             o_side
);

    logic                        r_vld  [rai_pkg::DVD_W];
    logic [rai_pkg::UD_W-1:0]    r_rem  [rai_pkg::DVD_W];
    logic [rai_pkg::DVD_W-1:0]   r_dvd  [rai_pkg::DVD_W];
    logic [rai_pkg::UD_W-1:0]    r_ud   [rai_pkg::DVD_W];
    rai_pkg::t_side              r_side [rai_pkg::DVD_W];

    genvar k;
    generate
        for (k = 0; k < rai_pkg::DVD_W; k++) begin : g_step
            logic                      s_vld;
            logic [rai_pkg::UD_W-1:0]  s_rem;
            logic [rai_pkg::UD_W-1:0]  s_ud;
            logic [rai_pkg::DVD_W-1:0] s_dvd;
            rai_pkg::t_side            s_side;
            logic [rai_pkg::UD_W:0]    w_trial;
            logic                      w_ge;
            logic [rai_pkg::UD_W-1:0]  n_rem;
            logic [rai_pkg::DVD_W-1:0] n_dvd;

            if (k == 0) begin : g_head
                assign s_vld  = i_vld;
                assign s_rem  = '0;
                assign s_dvd  = {i_un, {rai_pkg::FRAC_W{1'b0}}};
                assign s_ud   = i_ud;
                assign s_side = i_side;
            end else begin : g_body
                assign s_vld  = r_vld[k-1];
                assign s_rem  = r_rem[k-1];
                assign s_dvd  = r_dvd[k-1];
                assign s_ud   = r_ud[k-1];
                assign s_side = r_side[k-1];
            end

            always_comb begin
                w_trial = {s_rem, s_dvd[rai_pkg::DVD_W-1]};
                w_ge    = (w_trial >= {1'b0, s_ud});
                if (w_ge) begin
                    n_rem = rai_pkg::UD_W'(w_trial - {1'b0, s_ud});
                end else begin
                    n_rem = rai_pkg::UD_W'(w_trial);
                end
                n_dvd = {s_dvd[rai_pkg::DVD_W-2:0], w_ge};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= s_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= n_rem;
                    r_dvd[k]  <= n_dvd;
                    r_ud[k]   <= s_ud;
                    r_side[k] <= s_side;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[rai_pkg::DVD_W-1];
    assign o_quo  = r_dvd[rai_pkg::DVD_W-1];
    assign o_side = r_side[rai_pkg::DVD_W-1];

endmodule

@@ rtl/core/ray_annulus_intersect_core.sv @@
// ----------------------------------------------------------------------------
// ray_annulus_intersect_core
// Tests a Q16.16 ray against a configured flat ring and returns the hit
// point and the ray-facing normal.
//
// Input channel i_valid/o_ready carries one ray (origin, direction) per
// transfer; output channel o_valid/i_ready carries one result per ray, in
// order. Ring parameters are written through i_cfg_we/i_cfg_addr/i_cfg_data;
// the user must write them only while no ray is in flight; the block does not enforce it.
// Most of the pipeline is the divider, one quotient bit per stage for the
// 68-bit plane distance.
// Throughput: one ray per cycle while the output is not stalled.
// A stalled output holds the whole pipeline in place: o_ready follows
// !o_valid || i_ready, and no stage advances until the result is taken.
// Reset (synchronous, active low) empties the pipeline and loads the
// register defaults: centre at the origin, normal +z, radii 0 and 1.0.
// A miss returns hit flag 0 with all other fields 0.
// ----------------------------------------------------------------------------
`include "ray_annulus_intersect_core_macros.svh"

module ray_annulus_intersect_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [rai_pkg::CFG_ADDR_W-1:0]          i_cfg_addr,
    input  logic [rai_pkg::CFG_DATA_W-1:0]          i_cfg_data,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [rai_pkg::COORD_W-1:0]      i_origin_x,
    input  logic signed [rai_pkg::COORD_W-1:0]      i_origin_y,
    input  logic signed [rai_pkg::COORD_W-1:0]      i_origin_z,
    input  logic signed [rai_pkg::COORD_W-1:0]      i_dir_x,
    input  logic signed [rai_pkg::COORD_W-1:0]      i_dir_y,
    input  logic signed [rai_pkg::COORD_W-1:0]      i_dir_z,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic                                    o_hit_flag,
    output logic signed [rai_pkg::COORD_W-1:0]      o_hit_x,
    output logic signed [rai_pkg::COORD_W-1:0]      o_hit_y,
    output logic signed [rai_pkg::COORD_W-1:0]      o_hit_z,
    output logic signed [rai_pkg::NORM_W-1:0]       o_facing_normal_x,
    output logic signed [rai_pkg::NORM_W-1:0]       o_facing_normal_y,
    output logic signed [rai_pkg::NORM_W-1:0]       o_facing_normal_z
);

    // configuration
    logic signed [rai_pkg::COORD_W-1:0] r_centre [rai_pkg::AXES];
    logic signed [rai_pkg::NORM_W-1:0]  r_norm   [rai_pkg::AXES];
    logic [rai_pkg::RAD_W-1:0]          r_rad_in;
    logic [rai_pkg::RAD_W-1:0]          r_rad_out;
    logic [rai_pkg::RSQ_W-1:0]          r_rin_sq;
    logic [rai_pkg::RSQ_W-1:0]          r_rout_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre[0] <= '0;
            r_centre[1] <= '0;
            r_centre[2] <= '0;
            r_norm[0]   <= '0;
            r_norm[1]   <= '0;
            r_norm[2]   <= rai_pkg::NORM_W'(1 << rai_pkg::FRAC_W);
            r_rad_in    <= '0;
            r_rad_out   <= rai_pkg::RAD_W'(1 << rai_pkg::FRAC_W);
        end else if (i_cfg_we) begin
            case (rai_pkg::t_cfg_addr'(i_cfg_addr))
                rai_pkg::REG_CENTRE_X:     r_centre[0] <= i_cfg_data;
                rai_pkg::REG_CENTRE_Y:     r_centre[1] <= i_cfg_data;
                rai_pkg::REG_CENTRE_Z:     r_centre[2] <= i_cfg_data;
                rai_pkg::REG_NORMAL_X:     r_norm[0]   <= i_cfg_data[rai_pkg::NORM_W-1:0];
                rai_pkg::REG_NORMAL_Y:     r_norm[1]   <= i_cfg_data[rai_pkg::NORM_W-1:0];
                rai_pkg::REG_NORMAL_Z:     r_norm[2]   <= i_cfg_data[rai_pkg::NORM_W-1:0];
                rai_pkg::REG_INNER_RADIUS: r_rad_in    <= i_cfg_data[rai_pkg::RAD_W-1:0];
                rai_pkg::REG_OUTER_RADIUS: r_rad_out   <= i_cfg_data[rai_pkg::RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rin_sq  <= r_rad_in * r_rad_in;
        r_rout_sq <= r_rad_out * r_rad_out;
    end

    // pipeline control
    logic w_en;
    logic r_out_vld;

    assign w_en    = !r_out_vld || i_ready;
    assign o_ready = w_en;

    logic signed [rai_pkg::COORD_W-1:0] w_org [rai_pkg::AXES];
    logic signed [rai_pkg::COORD_W-1:0] w_dir [rai_pkg::AXES];

    assign w_org[0] = i_origin_x;
    assign w_org[1] = i_origin_y;
    assign w_org[2] = i_origin_z;
    assign w_dir[0] = i_dir_x;
    assign w_dir[1] = i_dir_y;
    assign w_dir[2] = i_dir_z;

    // stage 1: centre - origin
    logic                               r_v1;
    logic signed [rai_pkg::COORD_W-1:0] r_org1  [rai_pkg::AXES];
    logic signed [rai_pkg::COORD_W-1:0] r_dir1  [rai_pkg::AXES];
    logic signed [rai_pkg::DIFF_W-1:0]  r_diff1 [rai_pkg::AXES];

    // stage 2: products with the normal
    logic                               r_v2;
    logic signed [rai_pkg::COORD_W-1:0] r_org2 [rai_pkg::AXES];
    logic signed [rai_pkg::COORD_W-1:0] r_dir2 [rai_pkg::AXES];
    logic signed [rai_pkg::NPROD_W-1:0] r_np2  [rai_pkg::AXES];
    logic signed [rai_pkg::DPROD_W-1:0] r_dp2  [rai_pkg::AXES];

    // stage 3: dot products
    logic                               r_v3;
    logic signed [rai_pkg::COORD_W-1:0] r_org3 [rai_pkg::AXES];
    logic signed [rai_pkg::COORD_W-1:0] r_dir3 [rai_pkg::AXES];
    logic signed [rai_pkg::NUM_W-1:0]   r_num3;
    logic signed [rai_pkg::DEN_W-1:0]   r_den3;

    // stage 4: magnitudes and miss test
    logic                               r_v4;
    logic [rai_pkg::UN_W-1:0]           r_un4;
    logic [rai_pkg::UD_W-1:0]           r_ud4;
    rai_pkg::t_side                     r_side4;
    logic signed [rai_pkg::NUM_W-1:0]   w_num_abs;
    logic signed [rai_pkg::DEN_W-1:0]   w_den_abs;
    rai_pkg::t_side                     n_side4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_comb begin
        w_num_abs = r_num3[rai_pkg::NUM_W-1] ? -r_num3 : r_num3;
        w_den_abs = r_den3[rai_pkg::DEN_W-1] ? -r_den3 : r_den3;
        for (int a = 0; a < rai_pkg::AXES; a++) begin
            n_side4.org[a] = r_org3[a];
            n_side4.dir[a] = r_dir3[a];
        end
        n_side4.miss    = (r_den3 == '0)
                       || ((r_num3 != '0)
                           && (r_num3[rai_pkg::NUM_W-1] != r_den3[rai_pkg::DEN_W-1]));
        n_side4.den_pos = !r_den3[rai_pkg::DEN_W-1] && (r_den3 != '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < rai_pkg::AXES; a++) begin
                r_org1[a]  <= w_org[a];
                r_dir1[a]  <= w_dir[a];
                r_diff1[a] <= rai_pkg::DIFF_W'(r_centre[a]) - rai_pkg::DIFF_W'(w_org[a]);
                r_org2[a]  <= r_org1[a];
                r_dir2[a]  <= r_dir1[a];
                r_np2[a]   <= r_norm[a] * r_diff1[a];
                r_dp2[a]   <= r_norm[a] * r_dir1[a];
                r_org3[a]  <= r_org2[a];
                r_dir3[a]  <= r_dir2[a];
            end
            r_num3  <= rai_pkg::NUM_W'(r_np2[0]) + rai_pkg::NUM_W'(r_np2[1])
                     + rai_pkg::NUM_W'(r_np2[2]);
            r_den3  <= rai_pkg::DEN_W'(r_dp2[0]) + rai_pkg::DEN_W'(r_dp2[1])
                     + rai_pkg::DEN_W'(r_dp2[2]);
            r_un4   <= rai_pkg::UN_W'(w_num_abs);
            r_ud4   <= rai_pkg::UD_W'(w_den_abs);
            r_side4 <= n_side4;
        end
    end

    // divider
    logic                        w_dv_vld;
    logic [rai_pkg::DVD_W-1:0]   w_quo;
    rai_pkg::t_side              w_dv_side;

    rai_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_v4),
        .i_un    (r_un4),
        .i_ud    (r_ud4),
        .i_side  (r_side4),
        .o_vld   (w_dv_vld),
        .o_quo   (w_quo),
        .o_side  (w_dv_side)
    );

    // stage 5: saturate t
    logic                                       r_v5;
    logic [rai_pkg::T_W-1:0]                    r_t5;
    rai_pkg::t_side                             r_side5;

    // stage 6: partial products t * |d|
    logic                                       r_v6;
    logic [rai_pkg::TL_W+rai_pkg::DMAG_W-1:0]   r_pl6 [rai_pkg::AXES];
    logic [rai_pkg::TH_W+rai_pkg::DMAG_W-1:0]   r_ph6 [rai_pkg::AXES];
    rai_pkg::t_side                             r_side6;
    logic [rai_pkg::DMAG_W-1:0]                 w_dmag [rai_pkg::AXES];

    // stage 7: offset along each axis
    logic                                       r_v7;
    logic [rai_pkg::P_W-1:0]                    r_p7 [rai_pkg::AXES];
    rai_pkg::t_side                             r_side7;
    logic [rai_pkg::OFS_W-1:0]                  w_prod [rai_pkg::AXES];

    // stage 8: hit point
    logic                                       r_v8;
    logic signed [rai_pkg::COORD_W-1:0]         r_h8 [rai_pkg::AXES];
    logic                                       r_miss8;
    logic                                       r_pos8;
    logic signed [rai_pkg::HSUM_W-1:0]          w_hsum [rai_pkg::AXES];
    logic signed [rai_pkg::COORD_W-1:0]         w_hclamp [rai_pkg::AXES];

    // stage 9: distance from centre per axis
    logic                                       r_v9;
    logic signed [rai_pkg::COORD_W-1:0]         r_h9 [rai_pkg::AXES];
    logic [rai_pkg::EMAG_W-1:0]                 r_e9 [rai_pkg::AXES];
    logic                                       r_miss9;
    logic                                       r_pos9;
    logic signed [rai_pkg::DIFF_W-1:0]          w_ediff [rai_pkg::AXES];
    logic signed [rai_pkg::DIFF_W-1:0]          w_eabs [rai_pkg::AXES];

    // stage 10: squares
    logic                                       r_v10;
    logic signed [rai_pkg::COORD_W-1:0]         r_h10 [rai_pkg::AXES];
    logic [rai_pkg::SQ_W-1:0]                   r_sq10 [rai_pkg::AXES];
    logic                                       r_miss10;
    logic                                       r_pos10;

    always_comb begin
        for (int a = 0; a < rai_pkg::AXES; a++) begin
            w_dmag[a] = r_side5.dir[a][rai_pkg::COORD_W-1]
                      ? rai_pkg::DMAG_W'(-r_side5.dir[a]) : r_side5.dir[a];
            w_prod[a] = {r_ph6[a], {rai_pkg::TL_W{1'b0}}} + rai_pkg::OFS_W'(r_pl6[a]);
            if (r_side7.dir[a][rai_pkg::COORD_W-1]) begin
                w_hsum[a] = rai_pkg::HSUM_W'($signed(r_side7.org[a]))
                          - $signed({2'b00, r_p7[a]});
            end else begin
                w_hsum[a] = rai_pkg::HSUM_W'($signed(r_side7.org[a]))
                          + $signed({2'b00, r_p7[a]});
            end
            if ((&w_hsum[a][rai_pkg::HSUM_W-1:rai_pkg::COORD_W-1])
                || !(|w_hsum[a][rai_pkg::HSUM_W-1:rai_pkg::COORD_W-1])) begin
                w_hclamp[a] = w_hsum[a][rai_pkg::COORD_W-1:0];
            end else if (w_hsum[a][rai_pkg::HSUM_W-1]) begin
                w_hclamp[a] = {1'b1, {(rai_pkg::COORD_W-1){1'b0}}};
            end else begin
                w_hclamp[a] = {1'b0, {(rai_pkg::COORD_W-1){1'b1}}};
            end
            w_ediff[a] = rai_pkg::DIFF_W'(r_h8[a]) - rai_pkg::DIFF_W'(r_centre[a]);
            w_eabs[a]  = w_ediff[a][rai_pkg::DIFF_W-1] ? -w_ediff[a] : w_ediff[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
            r_v7  <= 1'b0;
            r_v8  <= 1'b0;
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
        end else if (w_en) begin
            r_v5  <= w_dv_vld;
            r_v6  <= r_v5;
            r_v7  <= r_v6;
            r_v8  <= r_v7;
            r_v9  <= r_v8;
            r_v10 <= r_v9;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // t above the Q.F range saturates
            r_t5    <= (|w_quo[rai_pkg::DVD_W-1:rai_pkg::T_W]) ? '1 : w_quo[rai_pkg::T_W-1:0];
            r_side5 <= w_dv_side;
            r_side6 <= r_side5;
            r_side7 <= r_side6;
            r_miss8 <= r_side7.miss;
            r_pos8  <= r_side7.den_pos;
            r_miss9 <= r_miss8;
            r_pos9  <= r_pos8;
            r_miss10 <= r_miss9;
            r_pos10  <= r_pos9;
            for (int a = 0; a < rai_pkg::AXES; a++) begin
                r_pl6[a]  <= r_t5[rai_pkg::TL_W-1:0] * w_dmag[a];
                r_ph6[a]  <= r_t5[rai_pkg::T_W-1:rai_pkg::TL_W] * w_dmag[a];
                r_p7[a]   <= (|w_prod[a][rai_pkg::OFS_W-1:rai_pkg::T_W])
                           ? '1 : w_prod[a][rai_pkg::T_W-1:rai_pkg::FRAC_W];
                r_h8[a]   <= w_hclamp[a];
                r_h9[a]   <= r_h8[a];
                r_e9[a]   <= rai_pkg::EMAG_W'(w_eabs[a]);
                r_h10[a]  <= r_h9[a];
                r_sq10[a] <= r_e9[a] * r_e9[a];
            end
        end
    end

    // stage 11: radius test and output register
    logic [rai_pkg::DIST_W-1:0]        w_dist;
    logic [rai_pkg::SQ_W-1:0]          w_dist_sat;
    logic                              w_hit;
    logic                              r_hit;
    logic signed [rai_pkg::COORD_W-1:0] r_hx [rai_pkg::AXES];
    logic signed [rai_pkg::NORM_W-1:0]  r_nx [rai_pkg::AXES];

    always_comb begin
        w_dist = rai_pkg::DIST_W'(r_sq10[0]) + rai_pkg::DIST_W'(r_sq10[1])
               + rai_pkg::DIST_W'(r_sq10[2]);
        w_dist_sat = (|w_dist[rai_pkg::DIST_W-1:rai_pkg::SQ_W])
                   ? '1 : w_dist[rai_pkg::SQ_W-1:0];
        w_hit = !r_miss10
             && (w_dist_sat <= rai_pkg::SQ_W'(r_rout_sq))
             && (w_dist_sat >= rai_pkg::SQ_W'(r_rin_sq));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_v10;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit <= w_hit;
            for (int a = 0; a < rai_pkg::AXES; a++) begin
                r_hx[a] <= w_hit ? r_h10[a] : '0;
                if (!w_hit) begin
                    r_nx[a] <= '0;
                end else if (r_pos10) begin
                    r_nx[a] <= -r_norm[a];
                end else begin
                    r_nx[a] <= r_norm[a];
                end
            end
        end
    end

    assign o_valid           = r_out_vld;
    assign o_hit_flag        = r_hit;
    assign o_hit_x           = r_hx[0];
    assign o_hit_y           = r_hx[1];
    assign o_hit_z           = r_hx[2];
    assign o_facing_normal_x = r_nx[0];
    assign o_facing_normal_y = r_nx[1];
    assign o_facing_normal_z = r_nx[2];

    // a hit needs a nonzero denominator, so the normal cannot be zero
    `RAI_ASSERT(a_hit_normal_nonzero, o_valid && o_hit_flag, (o_facing_normal_x != '0) || (o_facing_normal_y != '0) || (o_facing_normal_z != '0))
    `RAI_ASSERT(a_miss_fields_zero, o_valid && !o_hit_flag, (o_hit_x == '0) && (o_hit_y == '0) && (o_hit_z == '0) && (o_facing_normal_x == '0) && (o_facing_normal_y == '0) && (o_facing_normal_z == '0))
    `RAI_ASSERT(a_parallel_is_miss, r_v4 && (r_ud4 == '0), r_side4.miss)
    `RAI_ASSERT_NEXT(a_stall_freezes_pipe, !w_en, $stable(r_v5) && $stable(r_v10) && $stable(r_v1))

endmodule
